// ----- rtl/f2ieee_pkg.sv -----
// ---------------------------------------------------------------------------
// f2ieee_pkg: shared constants and types
// Widths, scaling coefficients and exponent limits for the fixed-point to
// single-precision converter.
// ---------------------------------------------------------------------------
package f2ieee_pkg;

  localparam int WORD_W = 32;   // integer and fraction words, result word
  localparam int MANT_W = 28;   // working mantissa, leading one at bit 27
  localparam int COEF_W = 32;   // multiplier coefficient width
  localparam int PROD_W = MANT_W + COEF_W;
  localparam int BEXP_W = 10;
  localparam int DEXP_W = 10;
  localparam int EXP_W  = 14;   // working exponent, signed

  // m * 10 for a multiply step; (m * RECIP10) >> 35 gives floor(m / 10)
  localparam logic [COEF_W-1:0] TEN     = 32'd10;
  localparam logic [COEF_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int                QUO_LSB = 35;
  localparam int                QUO_W   = MANT_W - 3;  // 28-bit value / 10 < 2^25

  localparam int EXP_ADJ  = 22;
  localparam int EXP_BIAS = 128;
  // the final 24-bit normalization is always four right shifts
  localparam int EXP_FINAL_OFS = EXP_ADJ + 4 + EXP_BIAS;

  localparam logic signed [EXP_W-1:0] EXP_MIN = 14'sd1;
  localparam logic signed [EXP_W-1:0] EXP_MAX = 14'sd254;

  localparam logic [WORD_W-1:0] FLOAT_INF  = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] FLOAT_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic en;    // capture a new product
    logic div;   // reciprocal of ten instead of ten
  } mul_ctrl_t;

endpackage

// ----- rtl/f2ieee_mul_unit.sv -----
// ---------------------------------------------------------------------------
// f2ieee_mul_unit: shared scale-by-ten multiplier
// Multiplies the working mantissa by ten or by the fixed-point reciprocal of
// ten and registers the full product.
// ---------------------------------------------------------------------------
module f2ieee_mul_unit import f2ieee_pkg::*; (
  input  logic              clk,
  input  mul_ctrl_t         ctrl,
  input  logic [MANT_W-1:0] mant,
  output logic [PROD_W-1:0] prod_r
);

  logic [COEF_W-1:0] coef;
  logic [PROD_W-1:0] prod_nxt;

  assign coef     = ctrl.div ? RECIP10 : TEN;
  assign prod_nxt = PROD_W'(mant) * PROD_W'(coef);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- rtl/fixed_to_ieee_single_convert_core.sv -----
// ---------------------------------------------------------------------------
// fixed_to_ieee_single_convert_core: 32.32 fixed point to IEEE single
// Scales a fixed-point magnitude by a power of ten and packs it as an
// unsigned, truncated single-precision word with a range flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: integer and
//   fraction words, binary exponent and signed decimal exponent. The block
//   holds in_stall high while it works on a transaction and drops it again
//   once the result has been loaded into the output register.
//   Output channel (out_valid / out_stall) carries float_bits and range_flag.
//   The output register holds its transaction while out_stall is high; a new
//   input is accepted meanwhile, and its result waits in the sequencer until
//   the output register is free.
//   Steps: a zero magnitude goes from accept straight to the pack step. Otherwise
//   an accept, up to 4 right shifts, up to 59 fraction pulls (one bit per
//   cycle), the exits from the two normalize steps, then per unit of
//   |dec_exp| a launch, the product, 3 to 4 one-bit renormalizing shifts and
//   two normalize exits, then a final scale check and a pack step. The
//   one-bit shifter and the single shared multiplier set this sequence.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and empties
//   the output register.
// ---------------------------------------------------------------------------
module fixed_to_ieee_single_convert_core import f2ieee_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [WORD_W-1:0]        in_int_part,
  input  logic [WORD_W-1:0]        in_frac_part,
  input  logic [BEXP_W-1:0]        in_bin_exp,
  input  logic signed [DEXP_W-1:0] in_dec_exp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WORD_W-1:0]        out_float_bits,
  output logic                     out_range_flag
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NORM_R = 3'd1;
  localparam logic [2:0] ST_NORM_L = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_PACK   = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [WORD_W-1:0]        m_r, m_nxt;
  logic [WORD_W-1:0]        f_r, f_nxt;
  logic signed [EXP_W-1:0]  e_r, e_nxt;
  logic signed [DEXP_W-1:0] d_r, d_nxt;
  logic                     zero_r, zero_nxt;
  logic                     div_r, div_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]        out_bits_r, out_bits_nxt;
  logic                     out_flag_r, out_flag_nxt;

  mul_ctrl_t                mul_ctrl;
  logic [PROD_W-1:0]        prod_r;
  logic signed [EXP_W-1:0]  exp_final;
  logic                     in_fire;
  logic                     out_free;

  f2ieee_mul_unit u_mul (
    .clk    (clk),
    .ctrl   (mul_ctrl),
    .mant   (m_r[MANT_W-1:0]),
    .prod_r (prod_r)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign exp_final = e_r + EXP_W'(EXP_FINAL_OFS);

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    f_nxt         = f_r;
    e_nxt         = e_r;
    d_nxt         = d_r;
    zero_nxt      = zero_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bits_nxt  = out_bits_r;
    out_flag_nxt  = out_flag_r;
    mul_ctrl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          m_nxt    = in_int_part;
          f_nxt    = in_frac_part;
          e_nxt    = EXP_W'(in_bin_exp);
          d_nxt    = in_dec_exp;
          zero_nxt = (in_int_part == '0) && (in_frac_part == '0);
          state_nxt = zero_nxt ? ST_PACK : ST_NORM_R;
        end
      end
      ST_NORM_R: begin
        // drop low bits until nothing sits above bit 27
        if (m_r[WORD_W-1:MANT_W] != '0) begin
          m_nxt = {1'b0, m_r[WORD_W-1:1]};
          e_nxt = e_r + EXP_W'(1);
        end else begin
          state_nxt = ST_NORM_L;
        end
      end
      ST_NORM_L: begin
        // pull fraction bits up until the leading one reaches bit 27
        if (!m_r[MANT_W-1]) begin
          m_nxt = {m_r[WORD_W-2:0], f_r[WORD_W-1]};
          f_nxt = {f_r[WORD_W-2:0], 1'b0};
          e_nxt = e_r - EXP_W'(1);
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!d_r[DEXP_W-1] && (d_r != '0)) begin
          mul_ctrl.en  = 1'b1;
          mul_ctrl.div = 1'b0;
          div_nxt      = 1'b0;
          d_nxt        = d_r - DEXP_W'(1);
          state_nxt    = ST_MUL;
        end else if (d_r[DEXP_W-1]) begin
          mul_ctrl.en  = 1'b1;
          mul_ctrl.div = 1'b1;
          div_nxt      = 1'b1;
          d_nxt        = d_r + DEXP_W'(1);
          state_nxt    = ST_MUL;
        end else begin
          state_nxt = ST_PACK;
        end
      end
      ST_MUL: begin
        if (div_r) begin
          m_nxt = WORD_W'(prod_r[QUO_LSB +: QUO_W]);
          // fraction is spent by now; renormalize shifts in zeros
          f_nxt = '0;
        end else begin
          m_nxt = prod_r[WORD_W-1:0];
        end
        state_nxt = ST_NORM_R;
      end
      ST_PACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (zero_r) begin
            out_bits_nxt = FLOAT_ZERO;
            out_flag_nxt = 1'b0;
          end else if (exp_final < EXP_MIN) begin
            out_bits_nxt = FLOAT_ZERO;
            out_flag_nxt = 1'b1;
          end else if (exp_final > EXP_MAX) begin
            out_bits_nxt = FLOAT_INF;
            out_flag_nxt = 1'b1;
          end else begin
            out_bits_nxt = {1'b0, exp_final[7:0], m_r[MANT_W-2:4]};
            out_flag_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    f_r        <= f_nxt;
    e_r        <= e_nxt;
    d_r        <= d_nxt;
    zero_r     <= zero_nxt;
    div_r      <= div_nxt;
    out_bits_r <= out_bits_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_float_bits = out_bits_r;
  assign out_range_flag = out_flag_r;

`ifndef SYNTHESIS
  // the multiplier is only launched on a normalized 28-bit mantissa
  a_scale_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> (m_r[MANT_W-1] && (m_r[WORD_W-1:MANT_W] == '0)))
    else $error("mantissa not normalized at scale step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("block not busy after accepting a transaction");

  a_out_from_pack: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PACK))
    else $error("output loaded outside pack step");

  a_scale_done_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_NORM_R))
    else $error("product step did not return to renormalize");
`endif

endmodule

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb: testbench for fixed_to_ieee_single_convert_core
// Drives 32.32 fixed-point literals with binary and decimal exponents, works
// out the truncated single-precision word and range flag for each one, and
// compares every result in order. Runs under four sender/receiver idle mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import f2ieee_pkg::*;

  localparam logic [31:0] LEAD28    = 32'h0800_0000;
  localparam logic [31:0] OVER28    = 32'hF000_0000;
  localparam logic [31:0] OVER24    = 32'hFF00_0000;
  localparam logic [31:0] LEAD24    = 32'h0080_0000;
  localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
  localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
  localparam int          RANDOM_ITEMS = 1880;
  localparam int          PHASES       = 4;

  typedef struct {
    logic [WORD_W-1:0]        int_part;
    logic [WORD_W-1:0]        frac_part;
    logic [BEXP_W-1:0]        bin_exp;
    logic signed [DEXP_W-1:0] dec_exp;
  } literal_t;

  typedef struct {
    logic [WORD_W-1:0] bits;
    logic              flag;
  } float_res_t;

  class float_scoreboard;
    float_res_t pending_floats[$];
    literal_t   pending_lits[$];
    int         mismatches;
    int         checked;
    int         zeros;
    int         out_of_range;

    function float_res_t convert_to_single(literal_t lit);
      logic [31:0] m;
      logic [31:0] f;
      int          e;
      int          d;
      float_res_t  res;
      m = lit.int_part;
      f = lit.frac_part;
      e = int'(lit.bin_exp);
      d = int'($signed(lit.dec_exp));
      res.bits = FLOAT_ZERO;
      res.flag = 1'b0;
      if (m == 0 && f == 0) return res;
      // drop low bits of a wide integer word, then pull fraction bits in
      while ((m & OVER28) != 0) begin
        m = m >> 1;
        e++;
      end
      while ((m & LEAD28) == 0) begin
        m = {m[30:0], f[31]};
        f = f << 1;
        e--;
      end
      while (d > 0) begin
        m = m * 32'd10;
        while ((m & OVER28) != 0) begin
          m = m >> 1;
          e++;
        end
        d--;
      end
      while (d < 0) begin
        m = m / 32'd10;
        while ((m & LEAD28) == 0) begin
          m = m << 1;
          e--;
        end
        d++;
      end
      e += EXP_ADJ;
      while ((m & OVER24) != 0) begin
        m = m >> 1;
        e++;
      end
      while ((m & LEAD24) == 0) begin
        m = {m[30:0], f[31]};
        f = f << 1;
        e--;
      end
      e += EXP_BIAS;
      if (e < int'(EXP_MIN)) begin
        res.bits = FLOAT_ZERO;
        res.flag = 1'b1;
      end else if (e > int'(EXP_MAX)) begin
        res.bits = FLOAT_INF;
        res.flag = 1'b1;
      end else begin
        res.bits = (m & MANT_MASK) | ((32'(e) << 23) & EXP_MASK);
      end
      return res;
    endfunction

    function void note_literal(literal_t lit);
      pending_floats.push_back(convert_to_single(lit));
      pending_lits.push_back(lit);
    endfunction

    function void check_float(logic [WORD_W-1:0] bits, logic flag);
      float_res_t want;
      literal_t   lit;
      if (pending_floats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %h flag %b with no conversion pending", bits, flag);
        return;
      end
      want = pending_floats.pop_front();
      lit  = pending_lits.pop_front();
      checked++;
      if (bits !== want.bits || flag !== want.flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: int %h frac %h bexp %0d dexp %0d: got %h/%b, want %h/%b",
                   lit.int_part, lit.frac_part, lit.bin_exp, $signed(lit.dec_exp),
                   bits, flag, want.bits, want.flag);
      end else begin
        if (want.flag) out_of_range++;
        else if (want.bits == FLOAT_ZERO) zeros++;
      end
    endfunction

    function int pending();
      return pending_floats.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [WORD_W-1:0]        in_int_part;
  logic [WORD_W-1:0]        in_frac_part;
  logic [BEXP_W-1:0]        in_bin_exp;
  logic signed [DEXP_W-1:0] in_dec_exp;
  logic                     out_valid;
  logic                     out_stall;
  logic [WORD_W-1:0]        out_float_bits;
  logic                     out_range_flag;

  float_scoreboard sb;
  int              idle_pct;
  int              stall_pct;
  longint          cycles;
  longint          cycle_budget;
  int              sent;

  fixed_to_ieee_single_convert_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_int_part    (in_int_part),
    .in_frac_part   (in_frac_part),
    .in_bin_exp     (in_bin_exp),
    .in_dec_exp     (in_dec_exp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_float_bits (out_float_bits),
    .out_range_flag (out_range_flag)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver stalls at random, per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // observe both channels at the edge where a transaction completes
  always @(posedge clk) begin
    literal_t lit;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lit.int_part  = in_int_part;
        lit.frac_part = in_frac_part;
        lit.bin_exp   = in_bin_exp;
        lit.dec_exp   = in_dec_exp;
        sb.note_literal(lit);
      end
      if (out_valid && !out_stall)
        sb.check_float(out_float_bits, out_range_flag);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4 * cycle_budget + 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_literal(input logic [WORD_W-1:0] ip, input logic [WORD_W-1:0] fp,
                              input int be, input int de);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    // worst case: pulls, shifts and every step of each decimal unit
    cycle_budget = cycle_budget + 200 + 8 * ((de < 0) ? -de : de);
    in_valid     <= 1'b1;
    in_int_part  <= ip;
    in_frac_part <= fp;
    in_bin_exp   <= BEXP_W'(be);
    in_dec_exp   <= DEXP_W'(de);
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_random();
    logic [WORD_W-1:0] ip;
    logic [WORD_W-1:0] fp;
    int                be;
    int                de;
    int                pick;
    case ($urandom_range(0, 9))
      0:       ip = '0;
      1, 2, 3: ip = $urandom;
      4, 5, 6: ip = $urandom >> $urandom_range(0, 31);
      7:       ip = $urandom_range(1, 15);
      8:       ip = 32'h1 << $urandom_range(0, 31);
      default: ip = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 5))
      0:       fp = '0;
      1:       fp = $urandom >> $urandom_range(0, 31);
      default: fp = $urandom;
    endcase
    be = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 140) : $urandom_range(0, 1023);
    // keep most decimal exponents short; each unit costs a multiply and a renormalize pass
    pick = $urandom_range(0, 99);
    if (pick < 94)      de = int'($urandom_range(0, 80)) - 40;
    else if (pick < 98) de = int'($urandom_range(0, 400)) - 200;
    else                de = int'($urandom_range(0, 1023)) - 512;
    send_literal(ip, fp, be, de);
  endtask

  task automatic send_directed();
    send_literal(32'h0, 32'h0, 0, 0);
    send_literal(32'h0, 32'h0, 1023, -512);
    send_literal(32'h0, 32'h0, 512, 511);
    send_literal(32'h1, 32'h0, 0, 0);
    send_literal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_literal(32'h0800_0000, 32'h0, 0, 0);
    send_literal(32'h0FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_literal(32'h1000_0000, 32'h0, 0, 0);
    send_literal(32'h0, 32'h8000_0000, 0, 0);
    send_literal(32'h0, 32'h1, 0, 0);
    send_literal(32'h0, 32'h1, 0, -40);
    send_literal(32'h1, 32'h0, 127, 0);
    send_literal(32'h1, 32'h0, 128, 0);
    send_literal(32'h1, 32'h0, 0, 38);
    send_literal(32'h1, 32'h0, 0, 39);
    send_literal(32'h1, 32'h0, 0, -37);
    send_literal(32'h1, 32'h0, 0, -38);
    send_literal(32'h1, 32'h0, 0, -39);
    send_literal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023, 511);
    send_literal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, -512);
    send_literal(32'h1, 32'h0, 0, 511);
    send_literal(32'd12345, 32'h8000_0000, 0, 3);
    send_literal(32'h3, 32'h0, 5, -1);
  endtask

  initial begin
    sb           = new();
    idle_pct     = 0;
    stall_pct    = 0;
    cycle_budget = 100;
    sent         = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_int_part  <= '0;
    in_frac_part <= '0;
    in_bin_exp   <= '0;
    in_dec_exp   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      if (phase == 0) send_directed();
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_random();
    end
    in_valid <= 1'b0;

    // drain, then keep watching so that any stray result shows
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d conversions over four idle/stall mixes; %0d results checked.",
             sent, sb.checked);
    $display("Zero results: %0d, out-of-range results: %0d, mismatches: %0d.",
             sb.zeros, sb.out_of_range, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
